// ===== design/trwb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trwb_pkg: shared types and constants of the thermostat relay
// Register indexes, request codes, the configuration bundle and defaults.
// ----------------------------------------------------------------------------
package trwb_pkg;

  localparam int unsigned QuietTicksDef   = 6000;
  localparam int unsigned PreBuzzTicksDef = 10;
  localparam int unsigned BuzzTicksDef    = 60;
  localparam int unsigned DelayShiftDef   = 7;

  // Only hysteresis >> BandShift sets the band.
  localparam int unsigned BandShift = 3;

  localparam int unsigned TempW    = 12;
  localparam int unsigned HystW    = 8;
  localparam int unsigned DelayW   = 8;
  localparam int unsigned HoldW    = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RELAY_POLARITY  = 3'd0,
    CFG_SET_POINT       = 3'd1,
    CFG_HYSTERESIS      = 3'd2,
    CFG_SWITCH_DELAY    = 3'd3,
    CFG_CONTROL_ENABLED = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    REQ_CONTROL = 1'b0,
    REQ_BUZZ    = 1'b1
  } req_e;

  typedef struct packed {
    logic                    relay_polarity;
    logic signed [TempW-1:0] set_point;
    logic [HystW-1:0]        hysteresis;
    logic [DelayW-1:0]       switch_delay;
    logic                    control_enabled;
  } cfg_t;

endpackage

// ===== design/trwb_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trwb_cfg_regs: configuration register file
// Write-only registers loaded by index; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module trwb_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [trwb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [trwb_pkg::CfgDataW-1:0] cfg_wdata_i,
  output trwb_pkg::cfg_t                cfg_o
);

  trwb_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (trwb_pkg::cfg_idx_e'(cfg_idx_i))
        trwb_pkg::CFG_RELAY_POLARITY:  cfg_d.relay_polarity  = cfg_wdata_i[0];
        trwb_pkg::CFG_SET_POINT:       cfg_d.set_point       = $signed(cfg_wdata_i);
        trwb_pkg::CFG_HYSTERESIS:      cfg_d.hysteresis      = cfg_wdata_i[7:0];
        trwb_pkg::CFG_SWITCH_DELAY:    cfg_d.switch_delay    = cfg_wdata_i[7:0];
        trwb_pkg::CFG_CONTROL_ENABLED: cfg_d.control_enabled = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{relay_polarity: 1'b0, set_point: '0, hysteresis: '0,
                 switch_delay: '0, control_enabled: 1'b1};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/trwb_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trwb_core: thermostat and buzz state update
// Holds heat state, hold counter, buzz counter and pin level; one update per
// step, producing the next pin level.
// ----------------------------------------------------------------------------
module trwb_core #(
  parameter int unsigned QUIET_TICKS    = trwb_pkg::QuietTicksDef,
  parameter int unsigned PRE_BUZZ_TICKS = trwb_pkg::PreBuzzTicksDef,
  parameter int unsigned BUZZ_TICKS     = trwb_pkg::BuzzTicksDef,
  parameter int unsigned DELAY_SHIFT    = trwb_pkg::DelayShiftDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  trwb_pkg::cfg_t                   cfg_i,
  input  logic                             step_i,
  input  logic                             req_type_i,
  input  logic signed [trwb_pkg::TempW-1:0] temperature_i,
  output logic                             pin_d_o
);

  localparam int unsigned TotalTicks = QUIET_TICKS + PRE_BUZZ_TICKS + BUZZ_TICKS;
  localparam int unsigned BuzzW      = $clog2(TotalTicks + 2);
  localparam int unsigned LimitW     = trwb_pkg::DelayW + DELAY_SHIFT;
  localparam int unsigned CmpW       = trwb_pkg::HoldW + 1;
  localparam int unsigned BandW      = trwb_pkg::HystW - trwb_pkg::BandShift;
  localparam int unsigned WideW      = trwb_pkg::TempW + 1;

  localparam logic [BuzzW-1:0] TotalLim = BuzzW'(TotalTicks);
  localparam logic [BuzzW-1:0] ToggLim  = BuzzW'(QUIET_TICKS + PRE_BUZZ_TICKS);
  localparam logic [BuzzW-1:0] QuietLim = BuzzW'(QUIET_TICKS);
  localparam logic [trwb_pkg::HoldW-1:0] HoldMax = '1;

  logic                       heat_q, heat_d;
  logic [trwb_pkg::HoldW-1:0] hold_q, hold_d;
  logic [BuzzW-1:0]           buzz_q, buzz_d, buzz_inc;
  logic                       pin_q, pin_d;

  logic [BandW-1:0]        band;
  logic signed [WideW-1:0] temp_w, low_bound, high_bound;
  logic [LimitW-1:0]       limit;
  logic                    beyond;
  logic [trwb_pkg::HoldW-1:0] hold_inc;
  logic                    mode;

  always_comb begin
    band       = cfg_i.hysteresis[trwb_pkg::HystW-1:trwb_pkg::BandShift];
    temp_w     = WideW'(temperature_i);
    low_bound  = WideW'($signed(cfg_i.set_point)) - $signed(WideW'(band));
    high_bound = WideW'($signed(cfg_i.set_point)) + $signed(WideW'(band));
    beyond     = heat_q ? (temp_w < low_bound) : (temp_w > high_bound);
    limit      = LimitW'(cfg_i.switch_delay) << DELAY_SHIFT;
    hold_inc   = (hold_q == HoldMax) ? hold_q : hold_q + 1'b1;
    buzz_inc   = buzz_q + 1'b1;
    mode       = cfg_i.relay_polarity;

    heat_d = heat_q;
    hold_d = hold_q;
    buzz_d = buzz_q;
    pin_d  = pin_q;

    if (trwb_pkg::req_e'(req_type_i) == trwb_pkg::REQ_CONTROL) begin
      if (cfg_i.control_enabled) begin
        if (!beyond) begin
          hold_d = '0;
        end else begin
          hold_d = hold_inc;
          if (CmpW'(limit) < CmpW'(hold_inc)) begin
            heat_d = ~heat_q;
          end
        end
        pin_d = heat_d ? mode : ~mode;
      end else begin
        pin_d = mode;
      end
    end else if (!cfg_i.control_enabled) begin
      // Quiet, then forced off, then toggle, then restore and wrap.
      buzz_d = buzz_inc;
      if (buzz_inc > TotalLim) begin
        buzz_d = '0;
        pin_d  = mode;
      end else if (buzz_inc > ToggLim) begin
        pin_d = ~pin_q;
      end else if (buzz_inc > QuietLim) begin
        pin_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heat_q <= 1'b0;
      hold_q <= '0;
      buzz_q <= '0;
      pin_q  <= 1'b0;
    end else if (step_i) begin
      heat_q <= heat_d;
      hold_q <= hold_d;
      buzz_q <= buzz_d;
      pin_q  <= pin_d;
    end
  end

  assign pin_d_o = pin_d;

  a_buzz_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    buzz_q <= TotalLim)
    else $error("buzz counter past its last phase");

  a_hold_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !req_type_i && cfg_i.control_enabled && !beyond |=> hold_q == '0)
    else $error("hold counter not cleared inside the band");

  a_heat_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !cfg_i.control_enabled |=> $stable(heat_q) && $stable(hold_q))
    else $error("thermostat state moved while control disabled");

endmodule

// ===== design/thermostat_relay_with_buzz.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermostat_relay_with_buzz: on/off thermostat relay driver with buzz pattern
// Input register, state update, result register.
// ----------------------------------------------------------------------------
// Each accepted tick yields exactly one relay level. The block takes one tick
// per clock cycle while in_stall_o is low; an accepted tick waits in the input
// register until the result register is free or draining, and its level is
// then loaded into the result register. The rate is set by the update of the
// thermostat and buzz state, which every tick reads and writes.
// The output register lets a new tick enter while a result waits to be taken.
module thermostat_relay_with_buzz #(
  parameter int unsigned QUIET_TICKS    = trwb_pkg::QuietTicksDef,
  parameter int unsigned PRE_BUZZ_TICKS = trwb_pkg::PreBuzzTicksDef,
  parameter int unsigned BUZZ_TICKS     = trwb_pkg::BuzzTicksDef,
  parameter int unsigned DELAY_SHIFT    = trwb_pkg::DelayShiftDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [trwb_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [trwb_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              req_type_i,
  input  logic signed [trwb_pkg::TempW-1:0] temperature_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              relay_level_o
);

  trwb_pkg::cfg_t cfg;

  logic                              in_valid_q;
  logic                              req_q;
  logic signed [trwb_pkg::TempW-1:0] temp_q;
  logic                              out_valid_q;
  logic                              level_q;
  logic                              pin_d;
  logic                              advance;
  logic                              accept;

  trwb_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Move a transaction into the result register when it is free or draining.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  trwb_core #(
    .QUIET_TICKS    (QUIET_TICKS),
    .PRE_BUZZ_TICKS (PRE_BUZZ_TICKS),
    .BUZZ_TICKS     (BUZZ_TICKS),
    .DELAY_SHIFT    (DELAY_SHIFT)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .step_i        (advance),
    .req_type_i    (req_q),
    .temperature_i (temp_q),
    .pin_d_o       (pin_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= req_type_i;
      temp_q <= temperature_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      level_q <= pin_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign relay_level_o = level_q;

  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result register empty after a transaction advanced");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !advance)
    else $error("waiting result overwritten");

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(req_q) && $stable(temp_q))
    else $error("stalled input transaction lost");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the thermostat relay with buzz pattern
// Drives control and buzz ticks through the valid/stall channel, programs the
// five registers between phases, and checks every relay level in order against
// an in-bench model of the hysteresis, hold counter and buzz phase logic.
// ----------------------------------------------------------------------------
module testbench;
  import trwb_pkg::*;

  localparam int IdlePct       = 29;
  localparam int ResetCycles   = 7;
  localparam int ResultLatency = 2;
  localparam int DrainLimit    = 2000;
  localparam int BuzzToggleAt  = QuietTicksDef + PreBuzzTicksDef;
  localparam int BuzzWrapAt    = QuietTicksDef + PreBuzzTicksDef + BuzzTicksDef;
  localparam int TempMin       = -(1 << (TempW - 1));
  localparam int TempMax       = (1 << (TempW - 1)) - 1;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  cfg_idx_e                cfg_idx = CFG_RELAY_POLARITY;
  logic [CfgDataW-1:0]     cfg_wdata = '0;
  logic                    tick_valid = 1'b0;
  logic                    tick_stall;
  req_e                    req_type = REQ_CONTROL;
  logic signed [TempW-1:0] temperature = '0;
  logic                    relay_valid;
  logic                    relay_stall = 1'b0;
  logic                    relay_level;

  // Shadow of the registers and of the relay state
  cfg_t shadow_cfg = '{relay_polarity: 1'b0, set_point: '0, hysteresis: '0,
                       switch_delay: '0, control_enabled: 1'b1};
  logic             heat_on = 1'b0;
  logic [HoldW-1:0] hold_cnt = '0;
  int               buzz_cnt = 0;
  logic             pin_now = 1'b0;

  logic expected_relay_q[$];
  logic relay_want;
  int   relay_errors = 0;
  int   ticks_sent = 0;
  int   relays_checked = 0;
  int   heat_flips = 0;
  int   buzz_steps = 0;
  bit   steady_flow = 1'b0;
  int   hold_off_req = 0;
  int   hold_off_left = 0;

  thermostat_relay_with_buzz #(
    .QUIET_TICKS   (QuietTicksDef),
    .PRE_BUZZ_TICKS(PreBuzzTicksDef),
    .BUZZ_TICKS    (BuzzTicksDef),
    .DELAY_SHIFT   (DelayShiftDef)
  ) DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (tick_valid),
    .in_stall_o   (tick_stall),
    .req_type_i   (req_type),
    .temperature_i(temperature),
    .out_valid_o  (relay_valid),
    .out_stall_i  (relay_stall),
    .relay_level_o(relay_level)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int hold_limit();
    return int'(shadow_cfg.switch_delay) << DelayShiftDef;
  endfunction

  function automatic int band_half();
    return int'(shadow_cfg.hysteresis >> BandShift);
  endfunction

  // Relay level after one tick; advances the shadow state
  function automatic logic thermostat_next_level(req_e kind, int temp_val);
    int  sp;
    bit  past_bound;
    sp = int'($signed(shadow_cfg.set_point));
    if (kind == REQ_CONTROL) begin
      if (shadow_cfg.control_enabled) begin
        past_bound = heat_on ? (temp_val < sp - band_half()) : (temp_val > sp + band_half());
        if (!past_bound) begin
          hold_cnt = '0;
        end else begin
          if (hold_cnt != '1) hold_cnt++;
          if (hold_limit() < int'(hold_cnt)) begin
            heat_on = !heat_on;
            heat_flips++;
          end
        end
        pin_now = heat_on ? shadow_cfg.relay_polarity : !shadow_cfg.relay_polarity;
      end else begin
        pin_now = shadow_cfg.relay_polarity;
      end
    end else if (!shadow_cfg.control_enabled) begin
      buzz_cnt++;
      buzz_steps++;
      if (buzz_cnt > BuzzWrapAt) begin
        buzz_cnt = 0;
        pin_now = shadow_cfg.relay_polarity;
      end else if (buzz_cnt > BuzzToggleAt) begin
        pin_now = !pin_now;
      end else if (buzz_cnt > QuietTicksDef) begin
        pin_now = 1'b0;
      end
    end
    return pin_now;
  endfunction

  // Random temperature beyond the bound of the current heat state
  function automatic int temp_past_bound();
    int sp;
    int lo;
    int hi;
    sp = int'($signed(shadow_cfg.set_point));
    if (heat_on) begin
      lo = TempMin;
      hi = sp - band_half() - 1;
    end else begin
      lo = sp + band_half() + 1;
      hi = TempMax;
    end
    if (hi < lo) return heat_on ? TempMin : TempMax;
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // Random temperature that clears the hold counter
  function automatic int temp_in_band();
    int sp;
    int lo;
    int hi;
    sp = int'($signed(shadow_cfg.set_point));
    if (heat_on) begin
      lo = (sp - band_half() < TempMin) ? TempMin : sp - band_half();
      hi = TempMax;
    end else begin
      lo = TempMin;
      hi = (sp + band_half() > TempMax) ? TempMax : sp + band_half();
    end
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int random_temp();
    return int'($urandom_range(TempMax - TempMin)) + TempMin;
  endfunction

  task automatic send_tick(input req_e kind, input int temp_val);
    while (!steady_flow && $urandom_range(99) < IdlePct) begin
      tick_valid <= 1'b0;
      @(posedge clk);
    end
    tick_valid  <= 1'b1;
    req_type    <= kind;
    temperature <= TempW'(temp_val);
    @(posedge clk);
    while (tick_stall) @(posedge clk);
    expected_relay_q.push_back(thermostat_next_level(kind, temp_val));
    ticks_sent++;
  endtask

  task automatic send_random_tick();
    send_tick(req_e'($urandom_range(1)), random_temp());
  endtask

  // Drop valid and wait until every relay level is back
  task automatic settle();
    tick_valid <= 1'b0;
    while (expected_relay_q.size() != 0) @(posedge clk);
    repeat (ResultLatency + 2) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int data);
    logic [CfgDataW-1:0] wdata;
    wdata = CfgDataW'(data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= wdata;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_RELAY_POLARITY:  shadow_cfg.relay_polarity  = wdata[0];
      CFG_SET_POINT:       shadow_cfg.set_point       = wdata[TempW-1:0];
      CFG_HYSTERESIS:      shadow_cfg.hysteresis      = wdata[HystW-1:0];
      CFG_SWITCH_DELAY:    shadow_cfg.switch_delay    = wdata[DelayW-1:0];
      CFG_CONTROL_ENABLED: shadow_cfg.control_enabled = wdata[0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input bit polarity, input int set_pt, input int hyst,
                              input int delay, input bit enabled);
    settle();
    write_reg(CFG_RELAY_POLARITY, int'(polarity));
    write_reg(CFG_SET_POINT, set_pt);
    write_reg(CFG_HYSTERESIS, hyst);
    write_reg(CFG_SWITCH_DELAY, delay);
    write_reg(CFG_CONTROL_ENABLED, int'(enabled));
  endtask

  task automatic apply_random_config(input bit allow_disable);
    int delay;
    int set_pt;
    bit enabled;
    delay   = ($urandom_range(5) == 0) ? int'($urandom_range(255)) : int'($urandom_range(2));
    set_pt  = ($urandom_range(3) == 0) ? random_temp() : int'($urandom_range(3000)) - 1500;
    enabled = allow_disable ? ($urandom_range(3) != 0) : 1'b1;
    apply_config(1'($urandom_range(1)), set_pt, int'($urandom_range(255)), delay, enabled);
  endtask

  // Reset values first, then the threshold at both ends of its range
  task automatic test_directed_edges();
    send_tick(REQ_CONTROL, 0);
    send_tick(REQ_CONTROL, 1);
    send_tick(REQ_BUZZ, TempMax);
    send_tick(REQ_CONTROL, -1);
    send_tick(REQ_CONTROL, TempMax);
    send_tick(REQ_CONTROL, TempMin);
    send_tick(REQ_CONTROL, 0);
    send_tick(REQ_BUZZ, TempMin);
    apply_config(1'b1, TempMax, 255, 0, 1'b1);
    send_tick(REQ_CONTROL, TempMax);
    send_tick(REQ_CONTROL, TempMin);
    send_tick(REQ_CONTROL, TempMin);
    send_tick(REQ_CONTROL, TempMax);
    apply_config(1'b0, TempMin, 0, 0, 1'b1);
    send_tick(REQ_CONTROL, TempMin);
    send_tick(REQ_CONTROL, TempMax);
    send_tick(REQ_CONTROL, TempMin);
    apply_config(1'b1, 0, 8, 0, 1'b0);
    send_tick(REQ_CONTROL, TempMax);
    send_tick(REQ_BUZZ, 0);
    send_tick(REQ_BUZZ, -1);
    send_tick(REQ_CONTROL, TempMin);
  endtask

  // Runs just short of, at and past the hold limit; continuing a run after a
  // switch flips straight back since the switch does not clear the counter
  task automatic test_switch_delay();
    int run_lens[4] = '{128, 129, 131, 5};
    apply_config(1'b0, 100, 80, 1, 1'b1);
    foreach (run_lens[k]) begin
      repeat (run_lens[k]) send_tick(REQ_CONTROL, temp_past_bound());
      send_tick(REQ_CONTROL, temp_in_band());
    end
  endtask

  // Buzz ticks mixed with forced control ticks at both polarities
  task automatic test_buzz_cycle();
    for (int pol = 0; pol < 2; pol++) begin
      apply_config(pol[0], 0, 0, 0, 1'b0);
      repeat (20) begin
        if ($urandom_range(9) == 0) send_tick(REQ_CONTROL, random_temp());
        else send_tick(REQ_BUZZ, random_temp());
      end
    end
  endtask

  task automatic test_steady_flow();
    apply_random_config(1'b0);
    steady_flow = 1'b1;
    repeat (50) begin
      if ($urandom_range(1)) send_tick(REQ_CONTROL, temp_past_bound());
      else send_random_tick();
    end
    steady_flow = 1'b0;
  endtask

  // Hold the result side off while ticks keep coming, so the input stalls
  task automatic test_backpressure();
    apply_random_config(1'b0);
    steady_flow  = 1'b1;
    hold_off_req = 300;
    repeat (50) begin
      if ($urandom_range(1)) send_tick(REQ_CONTROL, temp_past_bound());
      else send_random_tick();
    end
    steady_flow = 1'b0;
  endtask

  // Mostly runs beyond the bound ended by an in-band tick, plus noise
  task automatic test_random_phases();
    int sent;
    int run_len;
    repeat (2) begin
      apply_random_config(1'b1);
      sent = 0;
      while (sent < 40) begin
        if ($urandom_range(99) < 75) begin
          run_len = (hold_limit() > 130) ? int'($urandom_range(40))
                                         : int'($urandom_range(hold_limit() + 3));
          repeat (run_len) send_tick(REQ_CONTROL, temp_past_bound());
          send_tick(REQ_CONTROL, temp_in_band());
          sent += run_len + 1;
        end else begin
          send_random_tick();
          sent++;
        end
      end
    end
  endtask

  // Check each relay level against the oldest expectation; drive stall
  always @(posedge clk) begin
    if (rst_n) begin
      if (relay_valid === 1'b1 && !relay_stall) begin
        relays_checked++;
        if (expected_relay_q.size() == 0) begin
          $error("relay_level: no tick outstanding, actual %0b", relay_level);
          relay_errors++;
        end else begin
          relay_want = expected_relay_q.pop_front();
          if (relay_level !== relay_want) begin
            $error("relay_level: expected %0b, actual %0b", relay_want, relay_level);
            relay_errors++;
          end
        end
      end
      if (hold_off_req != 0) begin
        hold_off_left = hold_off_req;
        hold_off_req  = 0;
      end
      if (hold_off_left != 0) begin
        relay_stall <= 1'b1;
        hold_off_left--;
      end else begin
        relay_stall <= !steady_flow && ($urandom_range(99) < IdlePct);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_edges();
    test_switch_delay();
    test_steady_flow();
    test_backpressure();
    test_buzz_cycle();
    test_random_phases();
    tick_valid <= 1'b0;
    for (int i = 0; i < DrainLimit && expected_relay_q.size() != 0; i++) @(posedge clk);
    repeat (ResultLatency + 2) @(posedge clk);
    if (expected_relay_q.size() != 0) begin
      $error("relay_level: %0d expected levels never arrived", expected_relay_q.size());
      relay_errors++;
    end
    $display("Sent %0d ticks and checked %0d relay levels in order",
             ticks_sent, relays_checked);
    $display("Heat state changed %0d times; %0d buzz ticks stepped the buzz counter",
             heat_flips, buzz_steps);
    if (relay_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== thermostat_relay_with_buzz.f =====
design/trwb_pkg.sv
design/trwb_cfg_regs.sv
design/trwb_core.sv
design/thermostat_relay_with_buzz.sv
tb/sv/testbench.sv
